/* sv/vtab_pkg.sv */
// vtab_pkg: shared types and codes for the vertex/triangle adjacency builder.
// Used by the controller, datapath and top level; depends on nothing.
`timescale 1ns / 1ps
package vtab_pkg;
  localparam int unsigned MAX_VERTICES  = 1024;
  localparam int unsigned MAX_TRIANGLES = 2048;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_QVERT  = 2'd1;
  localparam logic [1:0] REQ_QSLOT  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_BUILD = 2'd2;

  localparam int unsigned CORNERS = 3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,     // sweep counts to zero
    OP_CNT_RD,    // read count of corner (sel)
    OP_CNT_WR,    // write count+1 of corner (sel)
    OP_TRI_WR,    // store triangle, bump loaded
    OP_PFX,       // prefix step at vertex idx
    OP_TRI_RD,    // read triangle idx
    OP_CUR_RD,    // read cursor of corner sel
    OP_CUR_WR,    // write pair and cursor+1 of corner sel
    OP_Q_RD,      // read query memories
    OP_FLAGS      // flag update
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic idx_last;   // sweep index reached its end
    logic tri_last;   // scatter reached last loaded triangle
    logic none_loaded;
  } sts_t;
endpackage

/* sv/vertex_triangle_adjacency_build_unit.sv */
// Vertex-to-triangle adjacency builder, counting sort into a CSR table.
// Append: flag check, three count read/write pairs, triangle store, back to idle; the
// first append after a build first reruns the count clear. Last triangle: prefix sweep,
// scatter (triangle read, three cursor read/write pairs per loaded triangle), done.
// Queries: memory read, then output. Reset: a clearing pass zeroes the counts; no beat is
// taken until it ends. A waiting result holds only the next item that has a result.
`timescale 1ns / 1ps
module vertex_triangle_adjacency_build_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: req_type[1:0], corner_a[11:2], corner_b[21:12], corner_c[31:22],
  // query_vertex[41:32], query_slot[54:42], zero fill to 56 bits
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_triangle
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: resp_kind[1:0], vertex_degree[14:2], first_slot[27:15],
  // next_vertex[37:28], prev_vertex[47:38], total_slots[60:48], status[62:61]
  output logic [63:0] m_axis_tdata
);
  vtab_pkg::cmd_t cmd;
  vtab_pkg::sts_t sts;
  logic fire, idle, resp, tri_ok, built;
  logic [1:0] kind, status;
  logic [12:0] deg, first, total;
  logic [9:0] nxt, prv;
  logic valid_q;
  logic [63:0] data_q;

  assign s_axis_tready = idle;
  assign fire = s_axis_tvalid && s_axis_tready;

  vtab_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .req_i(s_axis_tdata[1:0]),
    .last_i(s_axis_tlast), .tri_ok_i(tri_ok), .built_i(built), .out_busy_i(valid_q),
    .sts_i(sts), .cmd_o(cmd), .idle_o(idle), .resp_o(resp));

  vtab_dp u_dp (
    .clk_i, .rst_ni, .in_fire_i(fire), .req_i(s_axis_tdata[1:0]),
    .a_i(s_axis_tdata[11:2]), .b_i(s_axis_tdata[21:12]), .c_i(s_axis_tdata[31:22]),
    .qv_i(s_axis_tdata[41:32]), .qs_i(s_axis_tdata[54:42]),
    .cfg_we_i, .cfg_wd_i(cfg_wdata_i), .cmd_i(cmd), .sts_o(sts),
    .tri_ok_o(tri_ok), .built_o(built), .kind_o(kind), .deg_o(deg), .first_o(first),
    .next_o(nxt), .prev_o(prv), .total_o(total), .status_o(status));

  // hold the result beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (resp) valid_q <= 1'b1;
    else if (m_axis_tready) valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (resp) data_q <= {1'b0, status, total, prv, nxt, first, deg, kind};
  end
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
endmodule

/* sv/vtab_ram.sv */
// vtab_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vtab_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* sv/vtab_ctrl.sv */
// vtab_ctrl: sequencer for load, clear, prefix sum, scatter and queries.
// Depends on vtab_pkg.
`timescale 1ns / 1ps
module vtab_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic [1:0]      req_i,
  input  logic            last_i,
  input  logic            tri_ok_i,   // triangle in range and store not full
  input  logic            built_i,
  input  logic            out_busy_i, // output register still full
  input  vtab_pkg::sts_t  sts_i,
  output vtab_pkg::cmd_t  cmd_o,
  output logic            idle_o,
  output logic            resp_o
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_CRD   = 4'd2;
  localparam logic [3:0] S_CWR   = 4'd3;
  localparam logic [3:0] S_TWR   = 4'd4;
  localparam logic [3:0] S_PFX   = 4'd5;
  localparam logic [3:0] S_TRD   = 4'd6;
  localparam logic [3:0] S_URD   = 4'd7;
  localparam logic [3:0] S_UWR   = 4'd8;
  localparam logic [3:0] S_QRD   = 4'd9;
  localparam logic [3:0] S_QOUT  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;
  localparam logic [3:0] S_FLAG  = 4'd12;

  logic [3:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      sel_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      last_q  <= last_d;
    end
  end

  // a waiting result only holds the next item that has a result of its own
  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    last_d  = last_q;
    cmd_o   = '{op: vtab_pkg::OP_NONE, sel: sel_q};
    resp_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          last_d = last_i;
          sel_d  = '0;
          if (req_i == vtab_pkg::REQ_APPEND) begin
            if (built_i) begin
              state_d = S_CLR;
            end else begin
              state_d = S_FLAG;
            end
          end else if (req_i == vtab_pkg::REQ_QVERT || req_i == vtab_pkg::REQ_QSLOT) begin
            state_d = S_QRD;
          end
        end
      end
      S_CLR: begin
        cmd_o.op = vtab_pkg::OP_CLEAR;
        if (sts_i.idx_last) begin
          // after reset go idle; a new mesh goes on to handle its triangle
          state_d = built_i ? S_FLAG : S_IDLE;
        end
      end
      S_FLAG: begin
        cmd_o.op = vtab_pkg::OP_FLAGS;
        if (tri_ok_i) begin
          state_d = S_CRD;
        end else if (last_q) begin
          state_d = S_PFX;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CRD: begin
        cmd_o.op = vtab_pkg::OP_CNT_RD;
        state_d  = S_CWR;
      end
      S_CWR: begin
        cmd_o.op = vtab_pkg::OP_CNT_WR;
        if (sel_q == 2'd2) begin
          sel_d   = '0;
          state_d = S_TWR;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = S_CRD;
        end
      end
      S_TWR: begin
        cmd_o.op = vtab_pkg::OP_TRI_WR;
        state_d  = last_q ? S_PFX : S_IDLE;
      end
      S_PFX: begin
        cmd_o.op = vtab_pkg::OP_PFX;
        if (sts_i.idx_last) begin
          state_d = sts_i.none_loaded ? S_DONE : S_TRD;
        end
      end
      S_TRD: begin
        cmd_o.op = vtab_pkg::OP_TRI_RD;
        sel_d    = '0;
        state_d  = S_URD;
      end
      S_URD: begin
        cmd_o.op = vtab_pkg::OP_CUR_RD;
        state_d  = S_UWR;
      end
      S_UWR: begin
        cmd_o.op = vtab_pkg::OP_CUR_WR;
        if (sel_q == 2'd2) begin
          sel_d   = '0;
          state_d = sts_i.tri_last ? S_DONE : S_TRD;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = S_URD;
        end
      end
      S_DONE: begin
        if (!out_busy_i) begin
          resp_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_QRD: begin
        cmd_o.op = vtab_pkg::OP_Q_RD;
        state_d  = S_QOUT;
      end
      S_QOUT: begin
        if (!out_busy_i) begin
          resp_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

/* sv/vtab_dp.sv */
// vtab_dp: memories, counters and result formation for the adjacency builder.
// Depends on vtab_pkg and vtab_ram.
`timescale 1ns / 1ps
module vtab_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic [1:0]      req_i,
  input  logic [9:0]      a_i,
  input  logic [9:0]      b_i,
  input  logic [9:0]      c_i,
  input  logic [9:0]      qv_i,
  input  logic [12:0]     qs_i,
  input  logic            cfg_we_i,
  input  logic [10:0]     cfg_wd_i,
  input  vtab_pkg::cmd_t  cmd_i,
  output vtab_pkg::sts_t  sts_o,
  output logic            tri_ok_o,
  output logic            built_o,
  output logic [1:0]      kind_o,
  output logic [12:0]     deg_o,
  output logic [12:0]     first_o,
  output logic [9:0]      next_o,
  output logic [9:0]      prev_o,
  output logic [12:0]     total_o,
  output logic [1:0]      status_o
);
  localparam int unsigned MaxVertices  = vtab_pkg::MAX_VERTICES;
  localparam int unsigned MaxTriangles = vtab_pkg::MAX_TRIANGLES;
  localparam int unsigned VW = $clog2(MaxVertices);
  localparam int unsigned TW = $clog2(MaxTriangles);
  localparam int unsigned SlotDepth = vtab_pkg::CORNERS * MaxTriangles;
  localparam int unsigned SW = $clog2(SlotDepth);

  logic [10:0] vtot_q;
  logic [VW:0] vt;
  logic [TW:0] loaded_q;
  logic built_q, err_q, ovf_q;
  logic [VW:0] idx_q;          // sweep counter, one bit wider than a vertex index; wraps to 0 after the last vertex
  logic [TW-1:0] tidx_q;
  logic [1:0] req_q;
  logic [9:0] a_q, b_q, c_q, qv_q;
  logic [12:0] qs_q;
  logic [12:0] run_q;
  logic [12:0] deg_q;          // corner count captured for queries
  logic qrange_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vtot_q <= 11'd1024;
    else if (cfg_we_i) vtot_q <= cfg_wd_i;
  end
  assign vt = (32'(vtot_q) > MaxVertices) ? (VW+1)'(MaxVertices) : (VW+1)'(vtot_q);

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      req_q <= req_i; a_q <= a_i; b_q <= b_i; c_q <= c_i; qv_q <= qv_i; qs_q <= qs_i;
    end
  end

  logic in_rng;
  assign in_rng = (32'(a_q) < 32'(vt)) && (32'(b_q) < 32'(vt)) && (32'(c_q) < 32'(vt));
  assign tri_ok_o = in_rng && (32'(loaded_q) < MaxTriangles);
  assign built_o = built_q;

  // corner pick from selector
  logic [9:0] cv;
  always_comb begin
    unique case (cmd_i.sel)
      2'd0: cv = a_q;
      2'd1: cv = b_q;
      default: cv = c_q;
    endcase
  end

  // triangle store
  logic tri_we;
  logic [29:0] tri_rd;
  assign tri_we = cmd_i.op == vtab_pkg::OP_TRI_WR;
  vtab_ram #(.Width(30), .Depth(MaxTriangles)) u_tri (
    .clk_i, .we_i(tri_we), .waddr_i(loaded_q[TW-1:0]), .wdata_i({c_q, b_q, a_q}),
    .raddr_i(tidx_q), .rdata_o(tri_rd));

  // scatter corner values: the read row holds while tidx_q stands still
  logic [9:0] ta, tb, tc, sv, snx, spv;
  assign ta = tri_rd[9:0];
  assign tb = tri_rd[19:10];
  assign tc = tri_rd[29:20];
  always_comb begin
    unique case (cmd_i.sel)
      2'd0: begin sv = ta; snx = tb; spv = tc; end
      2'd1: begin sv = tb; snx = tc; spv = ta; end
      default: begin sv = tc; snx = ta; spv = tb; end
    endcase
  end

  // corner count memory
  logic cnt_we;
  logic [VW-1:0] cnt_wa, cnt_ra;
  logic [12:0] cnt_wd, cnt_rd;
  always_comb begin
    cnt_we = 1'b0; cnt_wa = cv[VW-1:0]; cnt_wd = cnt_rd + 13'd1; cnt_ra = cv[VW-1:0];
    unique case (cmd_i.op)
      vtab_pkg::OP_CLEAR: begin cnt_we = 1'b1; cnt_wa = idx_q[VW-1:0]; cnt_wd = '0; end
      vtab_pkg::OP_CNT_WR: cnt_we = 1'b1;
      vtab_pkg::OP_PFX: cnt_ra = idx_q[VW-1:0] + VW'(1);
      default: cnt_ra = (in_fire_i) ? qv_i[VW-1:0] :
                        (cmd_i.op == vtab_pkg::OP_NONE ? VW'(0) : cv[VW-1:0]);
    endcase
    if (cmd_i.op == vtab_pkg::OP_FLAGS || cmd_i.op == vtab_pkg::OP_CNT_WR)
      cnt_ra = VW'(0);
    if (cmd_i.op == vtab_pkg::OP_TRI_WR) cnt_ra = VW'(0);
    if (cmd_i.op == vtab_pkg::OP_CLEAR) cnt_ra = VW'(0);
  end
  vtab_ram #(.Width(13), .Depth(MaxVertices)) u_cnt (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_wa), .wdata_i(cnt_wd), .raddr_i(cnt_ra),
    .rdata_o(cnt_rd));

  // start offsets and cursors: written together in the prefix sweep
  logic off_we, cur_we;
  logic [VW-1:0] off_ra, cur_wa;
  logic [12:0] off_rd, cur_wd, cur_rd;
  assign off_we = cmd_i.op == vtab_pkg::OP_PFX;
  assign off_ra = in_fire_i ? qv_i[VW-1:0] : qv_q[VW-1:0];
  vtab_ram #(.Width(13), .Depth(MaxVertices)) u_off (
    .clk_i, .we_i(off_we), .waddr_i(idx_q[VW-1:0]), .wdata_i(run_q), .raddr_i(off_ra),
    .rdata_o(off_rd));
  assign cur_we = off_we || cmd_i.op == vtab_pkg::OP_CUR_WR;
  assign cur_wa = off_we ? idx_q[VW-1:0] : sv[VW-1:0];
  assign cur_wd = off_we ? run_q : cur_rd + 13'd1;
  vtab_ram #(.Width(13), .Depth(MaxVertices)) u_cur (
    .clk_i, .we_i(cur_we), .waddr_i(cur_wa), .wdata_i(cur_wd), .raddr_i(sv[VW-1:0]),
    .rdata_o(cur_rd));

  // neighbor table
  logic nb_we;
  logic [19:0] nb_rd;
  assign nb_we = (cmd_i.op == vtab_pkg::OP_CUR_WR) && (32'(cur_rd) < SlotDepth);
  vtab_ram #(.Width(20), .Depth(SlotDepth)) u_nb (
    .clk_i, .we_i(nb_we), .waddr_i(cur_rd[SW-1:0]), .wdata_i({spv, snx}),
    .raddr_i(qs_q[SW-1:0]), .rdata_o(nb_rd));

  logic [TW+2:0] total;
  assign total = (TW+3)'(loaded_q) + ((TW+3)'(loaded_q) << 1);

  assign sts_o.idx_last    = (32'(idx_q) == MaxVertices - 1);
  assign sts_o.tri_last    = (32'(tidx_q) + 1 >= 32'(loaded_q));
  assign sts_o.none_loaded = (loaded_q == '0);

  // pfx sweep: counts are read one ahead; first entry is read at the store/flag step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0; built_q <= 1'b0; err_q <= 1'b0; ovf_q <= 1'b0;
      idx_q <= '0; tidx_q <= '0; run_q <= '0;
    end else begin
      unique case (cmd_i.op)
        vtab_pkg::OP_CLEAR: begin
          idx_q <= sts_o.idx_last ? '0 : idx_q + 1'b1;
          if (sts_o.idx_last) begin
            loaded_q <= '0; built_q <= 1'b0; err_q <= 1'b0; ovf_q <= 1'b0;
          end
        end
        vtab_pkg::OP_FLAGS: begin
          if (!in_rng) err_q <= 1'b1;
          else if (32'(loaded_q) >= MaxTriangles) ovf_q <= 1'b1;
          idx_q <= '0; run_q <= '0;
        end
        vtab_pkg::OP_TRI_WR: begin
          loaded_q <= loaded_q + 1'b1; idx_q <= '0; run_q <= '0;
        end
        vtab_pkg::OP_PFX: begin
          // cnt_rd holds count[idx]: read one ahead, primed by the store or flag step's address-0 read
          run_q <= run_q + cnt_rd;
          idx_q <= sts_o.idx_last ? '0 : idx_q + 1'b1;
          tidx_q <= '0;
          if (sts_o.idx_last) built_q <= 1'b1;
        end
        vtab_pkg::OP_CUR_WR: begin
          if (cmd_i.sel == 2'd2) tidx_q <= tidx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == vtab_pkg::OP_Q_RD) begin
      qrange_q <= (req_q == vtab_pkg::REQ_QVERT) ? (32'(qv_q) < 32'(vt))
                                                 : (32'(qs_q) < 32'(total));
      deg_q    <= cnt_rd;
    end
  end

  // result fields, captured into the output register at resp
  always_comb begin
    kind_o = req_q; deg_o = '0; first_o = '0; next_o = '0; prev_o = '0;
    total_o = 13'(total); status_o = vtab_pkg::ST_OK;
    if (req_q == vtab_pkg::REQ_APPEND) begin
      status_o = err_q ? vtab_pkg::ST_RANGE : (ovf_q ? vtab_pkg::ST_BUILD : vtab_pkg::ST_OK);
    end else if (!built_q) begin
      status_o = vtab_pkg::ST_BUILD;
    end else if (!qrange_q) begin
      status_o = vtab_pkg::ST_RANGE;
    end else if (req_q == vtab_pkg::REQ_QVERT) begin
      deg_o = deg_q; first_o = off_rd;
    end else begin
      next_o = nb_rd[9:0]; prev_o = nb_rd[19:10];
    end
  end
endmodule

/* tb/sv/tb_vertex_triangle_adjacency_build_unit.sv */
// Self-checking bench for vertex_triangle_adjacency_build_unit: random and directed
// triangle meshes and queries, checked against an in-bench counting-sort predictor.
// Depends on vtab_pkg and the unit's RTL only.
`timescale 1ns / 1ps
module tb_vertex_triangle_adjacency_build_unit;
  localparam int unsigned NVERT = 1024;
  localparam int unsigned NTRI  = 2048;
  localparam int unsigned NSLOT = vtab_pkg::CORNERS * NTRI;
  localparam logic [1:0] REQ_NOP    = 2'd3;  // reserved request, dropped by the unit
  localparam logic [1:0] KIND_BUILT = 2'd0;
  localparam logic [1:0] KIND_VERT  = 2'd1;
  localparam logic [1:0] KIND_SLOT  = 2'd2;

  // One request beat; bits [55:0] are the tdata layout, last rides on tlast.
  typedef struct packed {
    logic        last;
    logic        pad;
    logic [12:0] qslot;
    logic [9:0]  qvert;
    logic [9:0]  c;
    logic [9:0]  b;
    logic [9:0]  a;
    logic [1:0]  req;
  } mesh_req_t;

  // Response beat in m_axis_tdata order, lowest field last.
  typedef struct packed {
    logic        pad;
    logic [1:0]  status;
    logic [12:0] total;
    logic [9:0]  prev;
    logic [9:0]  next;
    logic [12:0] first;
    logic [12:0] degree;
    logic [1:0]  kind;
  } adj_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [63:0] m_axis_tdata;

  vertex_triangle_adjacency_build_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Mirror of the mesh state: stored triangles, corner counts, CSR offsets and table.
  logic [9:0]  tri_a [NTRI];
  logic [9:0]  tri_b [NTRI];
  logic [9:0]  tri_c [NTRI];
  int unsigned corner_cnt [NVERT];
  int unsigned first_of [NVERT];
  int unsigned fill_ptr [NVERT];
  logic [9:0]  slot_next [NSLOT];
  logic [9:0]  slot_prev [NSLOT];
  int unsigned tri_loaded;
  bit          built, bad_index, overflowed;
  logic [10:0] vert_total;

  mesh_req_t   pend_q[$];     // beats waiting to be offered
  adj_resp_t   resp_q[$];     // responses the unit still owes
  mesh_req_t   cur_beat;
  int          burst_left = 1, gap_left = 0;
  int          beats_taken = 0, resp_seen = 0, errors = 0, builds = 0;
  int          items_pushed = 0;

  task automatic clear_mesh();
    for (int v = 0; v < NVERT; v++) corner_cnt[v] = 0;
    tri_loaded = 0;
    built      = 1'b0;
    bad_index  = 1'b0;
    overflowed = 1'b0;
  endtask

  task automatic scatter_pair(int unsigned v, logic [9:0] nx, logic [9:0] pv);
    int unsigned s;
    s = fill_ptr[v];
    if (s < NSLOT) begin
      slot_next[s] = nx;
      slot_prev[s] = pv;
    end
    fill_ptr[v] = s + 1;
  endtask

  // Prefix sum over the counts, then scatter every loaded triangle's corners.
  task automatic build_csr();
    int unsigned run;
    run = 0;
    for (int v = 0; v < NVERT; v++) begin
      first_of[v] = run;
      fill_ptr[v] = run;
      run += corner_cnt[v];
    end
    for (int t = 0; t < tri_loaded; t++) begin
      scatter_pair(tri_a[t], tri_b[t], tri_c[t]);
      scatter_pair(tri_b[t], tri_c[t], tri_a[t]);
      scatter_pair(tri_c[t], tri_a[t], tri_b[t]);
    end
    built = 1'b1;
  endtask

  // Advance the mirror by one accepted beat and queue the response it owes, if any.
  task automatic predict_adjacency(mesh_req_t r);
    adj_resp_t   e;
    int unsigned vt;
    vt = (vert_total > NVERT) ? NVERT : vert_total;
    e  = '0;
    case (r.req)
      vtab_pkg::REQ_APPEND: begin
        if (built) clear_mesh();
        if (r.a >= vt || r.b >= vt || r.c >= vt) begin
          bad_index = 1'b1;
        end else if (tri_loaded >= NTRI) begin
          overflowed = 1'b1;
        end else begin
          tri_a[tri_loaded] = r.a;
          tri_b[tri_loaded] = r.b;
          tri_c[tri_loaded] = r.c;
          corner_cnt[r.a]++;
          corner_cnt[r.b]++;
          corner_cnt[r.c]++;
          tri_loaded++;
        end
        if (!r.last) return;
        build_csr();
        builds++;
        e.kind   = KIND_BUILT;
        e.status = bad_index ? vtab_pkg::ST_RANGE :
                   (overflowed ? vtab_pkg::ST_BUILD : vtab_pkg::ST_OK);
      end
      vtab_pkg::REQ_QVERT: begin
        e.kind = KIND_VERT;
        if (!built) e.status = vtab_pkg::ST_BUILD;
        else if (r.qvert >= vt) e.status = vtab_pkg::ST_RANGE;
        else begin
          e.degree = 13'(corner_cnt[r.qvert]);
          e.first  = 13'(first_of[r.qvert]);
        end
      end
      vtab_pkg::REQ_QSLOT: begin
        e.kind = KIND_SLOT;
        if (!built) e.status = vtab_pkg::ST_BUILD;
        else if (r.qslot >= vtab_pkg::CORNERS * tri_loaded || r.qslot >= NSLOT)
          e.status = vtab_pkg::ST_RANGE;
        else begin
          e.next = slot_next[r.qslot];
          e.prev = slot_prev[r.qslot];
        end
      end
      default: return;  // reserved request: no response
    endcase
    e.total = 13'(vtab_pkg::CORNERS * tri_loaded);
    resp_q.push_back(e);
  endtask

  // Driver: offer queued beats in bursts; never drop tvalid before the handshake.
  always @(posedge clk_i) begin
    logic nv;
    nv = s_valid;
    if (s_valid && s_axis_tready) begin
      predict_adjacency(cur_beat);
      beats_taken++;
      nv = 1'b0;
    end
    if (!nv && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pend_q.size() > 0) begin
        cur_beat = pend_q.pop_front();
        s_axis_tdata <= cur_beat[55:0];
        s_axis_tlast <= cur_beat.last;
        nv = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end
    end
    s_valid <= nv;
  end

  // Monitor: check each response beat and shape the ready pattern.
  int rx_mode = 0, rx_mode_left = 0, rx_stall = 0, long_hold = 0;
  bit long_done = 1'b0;
  always @(posedge clk_i) begin
    adj_resp_t got, e;
    got = m_axis_tdata;
    if (m_axis_tvalid && m_ready) begin
      resp_seen++;
      if (resp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual %h", $time, got);
      end else begin
        e = resp_q.pop_front();
        if (got.kind !== e.kind || got.degree !== e.degree || got.first !== e.first ||
            got.next !== e.next || got.prev !== e.prev || got.total !== e.total ||
            got.status !== e.status) begin
          errors++;
          $display("%0t: response mismatch", $time);
          $display("  expected kind=%0d deg=%0d first=%0d next=%0d prev=%0d total=%0d st=%0d",
                   e.kind, e.degree, e.first, e.next, e.prev, e.total, e.status);
          $display("  actual   kind=%0d deg=%0d first=%0d next=%0d prev=%0d total=%0d st=%0d",
                   got.kind, got.degree, got.first, got.next, got.prev, got.total,
                   got.status);
        end
      end
    end
    // Hold off once for a long stretch so the output reg backs up into the input.
    if (!long_done && beats_taken >= 300 && resp_q.size() > 0) begin
      long_done = 1'b1;
      long_hold = 600;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 300);
    end else begin
      rx_mode_left--;
    end
    if (long_hold > 0) begin
      long_hold--;
      m_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (rx_mode == 1 && $urandom_range(0, 1) == 0) rx_stall = $urandom_range(1, 3);
      if (rx_mode == 2 && $urandom_range(0, 3) == 0) rx_stall = $urandom_range(1, 12);
    end
  end

  task automatic push_beat(logic [1:0] req, logic [9:0] a, logic [9:0] b, logic [9:0] c,
                           logic last, logic [9:0] qv, logic [12:0] qs);
    mesh_req_t r;
    r.req = req; r.a = a; r.b = b; r.c = c; r.last = last;
    r.qvert = qv; r.qslot = qs; r.pad = 1'b0;
    pend_q.push_back(r);
    items_pushed++;
  endtask

  // Unused fields carry random junk so their input bits toggle.
  task automatic push_tri(logic [9:0] a, logic [9:0] b, logic [9:0] c, logic last);
    push_beat(vtab_pkg::REQ_APPEND, a, b, c, last, 10'($urandom), 13'($urandom));
  endtask

  task automatic push_qvert(logic [9:0] v);
    push_beat(vtab_pkg::REQ_QVERT, 10'($urandom), 10'($urandom), 10'($urandom),
              1'($urandom), v, 13'($urandom));
  endtask

  task automatic push_qslot(logic [12:0] s);
    push_beat(vtab_pkg::REQ_QSLOT, 10'($urandom), 10'($urandom), 10'($urandom),
              1'($urandom), 10'($urandom), s);
  endtask

  // Pause the sender until every owed response is back and the unit has gone quiet.
  task automatic drain();
    @(negedge clk_i);
    while (pend_q.size() > 0 || s_valid || resp_q.size() > 0 || !s_axis_tready)
      @(negedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_vert_total(logic [10:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    vert_total  = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [9:0] pick_corner(int unsigned vt);
    if (vt == 0 || $urandom_range(0, 24) == 0) return 10'($urandom);
    return 10'($urandom_range(0, vt - 1));
  endfunction

  // A whole mesh with random content, a few early queries, then a burst of queries.
  task automatic random_mesh(int unsigned ntri, int unsigned nq);
    int unsigned vt;
    vt = (vert_total > NVERT) ? NVERT : vert_total;
    for (int i = 0; i < ntri; i++) begin
      case ($urandom_range(0, 19))
        0: push_qvert(10'($urandom_range(0, vt + 1)));
        1: push_beat(REQ_NOP, 10'($urandom), 10'($urandom), 10'($urandom), 1'($urandom),
                     10'($urandom), 13'($urandom));
        default: ;
      endcase
      push_tri(pick_corner(vt), pick_corner(vt), pick_corner(vt), i == ntri - 1);
    end
    for (int i = 0; i < nq; i++) begin
      if ($urandom_range(0, 1) == 0) push_qvert(10'($urandom_range(0, vt + 1)));
      else if ($urandom_range(0, 9) == 0) push_qslot(13'($urandom));
      else push_qslot(13'($urandom_range(0, vtab_pkg::CORNERS * ntri + 2)));
    end
  endtask

  initial begin
    logic [10:0] vt_pick;
    clear_mesh();
    vert_total = 11'd1024;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: queries before any build, reserved request, extreme corners,
    // a degenerate last triangle, slot queries at and past the end.
    push_qvert(10'd0);
    push_qslot(13'd0);
    push_beat(REQ_NOP, '1, '1, '1, 1'b1, '1, '1);
    push_tri(10'd0, 10'd1, 10'd2, 1'b0);
    push_tri(10'd1023, 10'd1022, 10'd0, 1'b0);
    push_tri(10'd5, 10'd5, 10'd5, 1'b1);
    push_qvert(10'd0);
    push_qvert(10'd1023);
    push_qvert(10'd5);
    push_qslot(13'd0);
    push_qslot(13'd8);
    push_qslot(13'd9);
    push_qslot(13'd8191);

    // Small mesh with an out-of-range corner: flagged but still built.
    write_vert_total(11'd10);
    push_tri(10'd0, 10'd1, 10'd12, 1'b0);
    push_tri(10'd9, 10'd3, 10'd4, 1'b1);
    push_qvert(10'd9);
    push_qvert(10'd10);
    push_qslot(13'd2);

    // Zero vertices: every corner out of range, the dropped last still builds.
    write_vert_total(11'd0);
    push_tri(10'd0, 10'd0, 10'd0, 1'b1);
    push_qvert(10'd0);
    push_qslot(13'd0);

    // Random meshes across vertex totals, the extremes among them.
    write_vert_total(11'd2047);
    while (items_pushed < 1600) begin
      case ($urandom_range(0, 5))
        0: vt_pick = 11'd1;
        1: vt_pick = 11'd2;
        2: vt_pick = 11'd1024;
        3: vt_pick = 11'd2047;
        4: vt_pick = 11'($urandom_range(3, 40));
        default: vt_pick = 11'($urandom_range(0, 2047));
      endcase
      if ($urandom_range(0, 2) == 0) write_vert_total(vt_pick);
      random_mesh($urandom_range(1, 60), $urandom_range(5, 40));
    end

    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d beats, %0d responses, %0d table builds", beats_taken, resp_seen,
             builds);
    if (errors == 0) begin
      $display("vertex_triangle_adjacency_build_unit: match");
    end else begin
      $display("vertex_triangle_adjacency_build_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout waiting for the unit");
    $display("vertex_triangle_adjacency_build_unit: mismatch");
    $finish;
  end
endmodule
